// ----- design/jtl_pkg.sv -----
`timescale 1ns / 1ps

package jtl_pkg;

  // Field widths and defaults
  localparam int unsigned POSITION_BITS_DEF = 24;
  localparam int unsigned OUT_POS_BITS      = 24;
  localparam int unsigned KIND_BITS         = 4;
  localparam int unsigned MAX_TOKENS        = 3;
  localparam int unsigned COUNT_BITS        = 2;
  localparam int unsigned QUEUE_DEPTH       = 2;

  // Lexer modes
  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_STRING  = 3'd1,
    MODE_MINUS   = 3'd2,
    MODE_NUMBER  = 3'd3,
    MODE_KEYWORD = 3'd4,
    MODE_SKIP    = 3'd5
  } lex_mode_e;

  // Token kinds as they leave the block
  typedef enum logic [3:0] {
    TOK_INVALID  = 4'd0,
    TOK_EOF      = 4'd1,
    TOK_STRING   = 4'd2,
    TOK_COLON    = 4'd3,
    TOK_COMMA    = 4'd4,
    TOK_LBRACE   = 4'd5,
    TOK_RBRACE   = 4'd6,
    TOK_LBRACKET = 4'd7,
    TOK_RBRACKET = 4'd8,
    TOK_INT      = 4'd9,
    TOK_FLOAT    = 4'd10,
    TOK_BOOL     = 4'd11,
    TOK_NULL     = 4'd12
  } token_kind_e;

  // Keyword selector codes
  localparam logic [1:0] KW_TRUE  = 2'd0;
  localparam logic [1:0] KW_NULL  = 2'd1;
  localparam logic [1:0] KW_FALSE = 2'd2;

  // Characters the lexer looks at
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LOW_T  = 8'h74;
  localparam logic [7:0] CH_LOW_N  = 8'h6E;
  localparam logic [7:0] CH_LOW_F  = 8'h66;
  localparam logic [7:0] CH_LOW_R  = 8'h72;
  localparam logic [7:0] CH_LOW_U  = 8'h75;
  localparam logic [7:0] CH_LOW_E  = 8'h65;
  localparam logic [7:0] CH_LOW_L  = 8'h6C;
  localparam logic [7:0] CH_LOW_A  = 8'h61;
  localparam logic [7:0] CH_LOW_S  = 8'h73;

  // Queue status seen by the front
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Keyword length in letters
  function automatic logic [2:0] kw_len(input logic [1:0] kind);
    logic [2:0] len;
    len = (kind == KW_FALSE) ? 3'd5 : 3'd4;
    return len;
  endfunction

  // Token kind for a completed keyword
  function automatic token_kind_e kw_token(input logic [1:0] kind);
    token_kind_e tk;
    tk = (kind == KW_NULL) ? TOK_NULL : TOK_BOOL;
    return tk;
  endfunction

  // Letter of a keyword at a given index
  function automatic logic [7:0] kw_char(input logic [1:0] kind, input logic [2:0] idx);
    logic [7:0] ch;
    ch = 8'h00;
    case (kind)
      KW_NULL: begin
        case (idx)
          3'd0: ch = CH_LOW_N;
          3'd1: ch = CH_LOW_U;
          3'd2: ch = CH_LOW_L;
          3'd3: ch = CH_LOW_L;
          default: ch = 8'h00;
        endcase
      end
      KW_FALSE: begin
        case (idx)
          3'd0: ch = CH_LOW_F;
          3'd1: ch = CH_LOW_A;
          3'd2: ch = CH_LOW_L;
          3'd3: ch = CH_LOW_S;
          3'd4: ch = CH_LOW_E;
          default: ch = 8'h00;
        endcase
      end
      default: begin
        case (idx)
          3'd0: ch = CH_LOW_T;
          3'd1: ch = CH_LOW_R;
          3'd2: ch = CH_LOW_U;
          3'd3: ch = CH_LOW_E;
          default: ch = 8'h00;
        endcase
      end
    endcase
    return ch;
  endfunction

endpackage

// ----- design/jtl_front.sv -----
`timescale 1ns / 1ps

module jtl_front #(
  parameter int unsigned POSITION_BITS = jtl_pkg::POSITION_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          text_byte_i,
  input  logic                stream_end_i,
  input  jtl_pkg::q_status_t  q_status_i,
  output logic                push_o,
  output logic [jtl_pkg::COUNT_BITS + jtl_pkg::MAX_TOKENS *
                (jtl_pkg::KIND_BITS + 3 * POSITION_BITS) - 1:0] bundle_o
);
  import jtl_pkg::*;

  localparam int unsigned PB    = POSITION_BITS;
  localparam int unsigned TOK_W = KIND_BITS + 3 * PB;
  localparam int unsigned CAND  = 4;

  lex_mode_e        mode_q, mode_d;
  logic [PB-1:0]    pos_q, pos_d;
  logic [PB-1:0]    line_q, line_d;
  logic [PB-1:0]    start_q, start_d;
  logic [2:0]       kw_idx_q, kw_idx_d;
  logic [1:0]       kw_kind_q, kw_kind_d;
  logic             dot_q, dot_d;

  logic             accept;
  logic [PB-1:0]    pos_nxt;
  logic [PB-1:0]    line_inc;
  logic [1:0]       kk;
  logic             is_digit;

  logic             e_vld   [CAND];
  token_kind_e      e_kind  [CAND];
  logic [PB-1:0]    e_start [CAND];
  logic [PB-1:0]    e_end   [CAND];
  logic [PB-1:0]    e_line  [CAND];

  logic [TOK_W-1:0] tok     [MAX_TOKENS];
  logic [COUNT_BITS-1:0] cnt;

  assign accept   = in_valid_i && in_ready_o;
  assign in_ready_o = !q_status_i.full;
  assign pos_nxt  = (&pos_q) ? pos_q : pos_q + 1'b1;
  assign line_inc = (&line_q) ? line_q : line_q + 1'b1;
  assign kk       = (kw_kind_q == 2'd3) ? KW_TRUE : kw_kind_q;
  assign is_digit = (text_byte_i >= CH_ZERO) && (text_byte_i <= CH_NINE);

  // Lex one byte: next state and up to four candidate tokens
  always_comb begin
    logic do_idle;
    logic [2:0] idx_inc;
    mode_d    = mode_q;
    pos_d     = pos_q;
    line_d    = line_q;
    start_d   = start_q;
    kw_idx_d  = kw_idx_q;
    kw_kind_d = kw_kind_q;
    dot_d     = dot_q;
    do_idle   = 1'b0;
    idx_inc   = kw_idx_q + 3'd1;
    for (int i = 0; i < CAND; i++) begin
      e_vld[i]   = 1'b0;
      e_kind[i]  = TOK_INVALID;
      e_start[i] = start_q;
      e_end[i]   = pos_q;
      e_line[i]  = line_q;
    end

    // Continue the token in progress
    case (mode_q)
      MODE_STRING: begin
        if (text_byte_i == CH_QUOTE) begin
          e_vld[0]  = 1'b1;
          e_kind[0] = TOK_STRING;
          e_end[0]  = pos_nxt;
          mode_d    = MODE_IDLE;
        end
      end
      MODE_MINUS: begin
        if (is_digit) begin
          mode_d = MODE_NUMBER;
          dot_d  = 1'b0;
        end else begin
          e_vld[0] = 1'b1;
          mode_d   = MODE_SKIP;
        end
      end
      MODE_NUMBER: begin
        if (is_digit) begin
          mode_d = MODE_NUMBER;
        end else if (text_byte_i == CH_DOT) begin
          if (dot_q) begin
            e_vld[0] = 1'b1;
            mode_d   = MODE_SKIP;
          end else begin
            dot_d = 1'b1;
          end
        end else begin
          e_vld[0]  = 1'b1;
          e_kind[0] = dot_q ? TOK_FLOAT : TOK_INT;
          mode_d    = MODE_IDLE;
          do_idle   = 1'b1;
        end
      end
      MODE_KEYWORD: begin
        if (kw_idx_q < kw_len(kk) && text_byte_i == kw_char(kk, kw_idx_q)) begin
          kw_idx_d = idx_inc;
          if (idx_inc >= kw_len(kk) && !stream_end_i) begin
            e_vld[0]  = 1'b1;
            e_kind[0] = kw_token(kk);
            e_end[0]  = pos_nxt;
            mode_d    = MODE_IDLE;
          end
        end else begin
          e_vld[0] = 1'b1;
          mode_d   = MODE_SKIP;
        end
      end
      MODE_SKIP: begin
        mode_d = MODE_SKIP;
      end
      default: begin
        mode_d  = MODE_IDLE;
        do_idle = 1'b1;
      end
    endcase

    // Start a new token from idle
    if (do_idle) begin
      e_start[1] = pos_q;
      e_end[1]   = pos_nxt;
      case (text_byte_i)
        CH_SPACE, CH_CR: begin
          mode_d = MODE_IDLE;
        end
        CH_LF: begin
          line_d = line_inc;
        end
        CH_QUOTE: begin
          mode_d  = MODE_STRING;
          start_d = pos_q;
        end
        CH_COLON: begin
          e_vld[1]  = 1'b1;
          e_kind[1] = TOK_COLON;
        end
        CH_COMMA: begin
          e_vld[1]  = 1'b1;
          e_kind[1] = TOK_COMMA;
        end
        CH_LBRACE: begin
          e_vld[1]  = 1'b1;
          e_kind[1] = TOK_LBRACE;
        end
        CH_RBRACE: begin
          e_vld[1]  = 1'b1;
          e_kind[1] = TOK_RBRACE;
        end
        CH_LBRACK: begin
          e_vld[1]  = 1'b1;
          e_kind[1] = TOK_LBRACKET;
        end
        CH_RBRACK: begin
          e_vld[1]  = 1'b1;
          e_kind[1] = TOK_RBRACKET;
        end
        CH_MINUS: begin
          mode_d  = MODE_MINUS;
          start_d = pos_q;
        end
        CH_LOW_T, CH_LOW_N, CH_LOW_F: begin
          mode_d    = MODE_KEYWORD;
          start_d   = pos_q;
          kw_idx_d  = 3'd1;
          kw_kind_d = (text_byte_i == CH_LOW_T) ? KW_TRUE :
                      ((text_byte_i == CH_LOW_N) ? KW_NULL : KW_FALSE);
        end
        default: begin
          if (is_digit) begin
            mode_d  = MODE_NUMBER;
            start_d = pos_q;
            dot_d   = 1'b0;
          end else begin
            e_vld[1]  = 1'b1;
            e_kind[1] = TOK_INVALID;
            e_end[1]  = pos_q;
            mode_d    = MODE_SKIP;
          end
        end
      endcase
    end

    pos_d = pos_nxt;

    // Close the stream: flush the open token, then Eof, then reset
    if (stream_end_i) begin
      e_start[2] = start_d;
      e_end[2]   = pos_nxt;
      e_line[2]  = line_d;
      case (mode_d)
        MODE_STRING: begin
          e_vld[2]  = 1'b1;
          e_kind[2] = TOK_EOF;
        end
        MODE_MINUS, MODE_KEYWORD: begin
          e_vld[2]  = 1'b1;
          e_kind[2] = TOK_INVALID;
        end
        MODE_NUMBER: begin
          e_vld[2]  = 1'b1;
          e_kind[2] = dot_d ? TOK_FLOAT : TOK_INT;
        end
        default: begin
          e_vld[2] = 1'b0;
        end
      endcase
      e_vld[3]   = 1'b1;
      e_kind[3]  = TOK_EOF;
      e_start[3] = pos_nxt;
      e_end[3]   = pos_nxt;
      e_line[3]  = line_d;

      mode_d    = MODE_IDLE;
      pos_d     = '0;
      line_d    = '0;
      start_d   = '0;
      kw_idx_d  = 3'd0;
      kw_kind_d = KW_TRUE;
      dot_d     = 1'b0;
    end
  end

  // Pack the candidates into consecutive slots
  always_comb begin
    for (int i = 0; i < MAX_TOKENS; i++) begin
      tok[i] = '0;
    end
    cnt = '0;
    for (int i = 0; i < CAND; i++) begin
      if (e_vld[i] && cnt < COUNT_BITS'(MAX_TOKENS)) begin
        tok[cnt] = {e_kind[i], e_start[i], e_end[i], e_line[i]};
        cnt      = cnt + 1'b1;
      end
    end
  end

  assign bundle_o = {cnt, tok[2], tok[1], tok[0]};
  assign push_o   = accept && (cnt != '0);

  // Advance lexer state on each accepted word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_IDLE;
      pos_q     <= '0;
      line_q    <= '0;
      start_q   <= '0;
      kw_idx_q  <= 3'd0;
      kw_kind_q <= KW_TRUE;
      dot_q     <= 1'b0;
    end else if (accept) begin
      mode_q    <= mode_d;
      pos_q     <= pos_d;
      line_q    <= line_d;
      start_q   <= start_d;
      kw_idx_q  <= kw_idx_d;
      kw_kind_q <= kw_kind_d;
      dot_q     <= dot_d;
    end
  end

  // A closing byte leaves the lexer at the start of a fresh stream
  a_stream_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && stream_end_i |=> mode_q == MODE_IDLE && pos_q == '0 && line_q == '0)
    else $error("lexer state not cleared after stream end");

endmodule

// ----- design/jtl_fifo.sv -----
`timescale 1ns / 1ps

module jtl_fifo #(
  parameter int unsigned WIDTH = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  logic [WIDTH-1:0]   push_data_i,
  input  logic               pop_i,
  output logic [WIDTH-1:0]   head_o,
  output jtl_pkg::q_status_t status_o
);
  import jtl_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] slot_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;

  assign status_o.full  = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign status_o.empty = (cnt_q == '0);
  assign head_o         = slot_q[rd_ptr_q];

  // Hold bundles between front and back
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !status_o.full)
    else $error("bundle queue overflow");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !status_o.empty)
    else $error("bundle queue underflow");

endmodule

// ----- design/jtl_back.sv -----
`timescale 1ns / 1ps

module jtl_back #(
  parameter int unsigned POSITION_BITS = jtl_pkg::POSITION_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [jtl_pkg::COUNT_BITS + jtl_pkg::MAX_TOKENS *
                (jtl_pkg::KIND_BITS + 3 * POSITION_BITS) - 1:0] head_i,
  input  jtl_pkg::q_status_t        q_status_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [3:0]                token_kind_o,
  output logic [POSITION_BITS-1:0]  token_start_o,
  output logic [POSITION_BITS-1:0]  token_end_o,
  output logic [POSITION_BITS-1:0]  line_number_o,
  output logic                      run_last_o
);
  import jtl_pkg::*;

  localparam int unsigned PB    = POSITION_BITS;
  localparam int unsigned TOK_W = KIND_BITS + 3 * PB;
  localparam int unsigned CNT_LSB = MAX_TOKENS * TOK_W;

  logic [COUNT_BITS-1:0] idx_q, idx_d;
  logic [COUNT_BITS-1:0] head_cnt;
  logic [TOK_W-1:0]      sel_tok;
  logic                  load;
  logic                  is_last;

  logic                  valid_q;
  logic [3:0]            kind_q;
  logic [PB-1:0]         start_q, end_q, line_q;
  logic                  last_q;

  assign head_cnt = head_i[CNT_LSB +: COUNT_BITS];
  assign sel_tok  = head_i[idx_q * TOK_W +: TOK_W];
  assign is_last  = (idx_q == head_cnt - 1'b1);
  assign load     = (!valid_q || out_ready_i) && !q_status_i.empty;
  assign pop_o    = load && is_last;
  assign idx_d    = pop_o ? '0 : idx_q + 1'b1;

  // Walk the head bundle one token per word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (load) begin
        idx_q   <= idx_d;
        valid_q <= 1'b1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q  <= sel_tok[3*PB +: KIND_BITS];
      start_q <= sel_tok[2*PB +: PB];
      end_q   <= sel_tok[PB +: PB];
      line_q  <= sel_tok[0 +: PB];
      last_q  <= is_last;
    end
  end

  assign out_valid_o   = valid_q;
  assign token_kind_o  = kind_q;
  assign token_start_o = start_q;
  assign token_end_o   = end_q;
  assign line_number_o = line_q;
  assign run_last_o    = last_q;

  // A queued bundle always holds at least one token, and the walk stays inside it
  a_idx_in_bundle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !q_status_i.empty |-> head_cnt != '0 && idx_q < head_cnt)
    else $error("token index outside head bundle");

endmodule

// ----- design/json_token_lexer.sv -----
`timescale 1ns / 1ps
// Channel | Handshake            | Payload
// in      | in_valid_i/in_ready_o | text_byte_i, stream_end_i
// out     | out_valid_o/out_ready_i | token_kind_o, token_start_o, token_end_o,
//         |                        | line_number_o, run_last_o
//
// One byte is taken per cycle while the two-entry bundle queue has room.
// A byte makes zero to three tokens; the back end sends one token per cycle
// while the receiver is ready.
// The first token of a byte passes through the queue, then the output register.
// Reset clears the lexer to the start of a stream at position zero.
// Either side may stall: the queue and output register absorb the difference.

module json_token_lexer #(
  parameter int unsigned POSITION_BITS = jtl_pkg::POSITION_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  text_byte_i,
  input  logic        stream_end_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  token_kind_o,
  output logic [23:0] token_start_o,
  output logic [23:0] token_end_o,
  output logic [23:0] line_number_o,
  output logic        run_last_o
);
  import jtl_pkg::*;

  localparam int unsigned PB       = POSITION_BITS;
  localparam int unsigned BUNDLE_W = COUNT_BITS + MAX_TOKENS * (KIND_BITS + 3 * PB);

  logic [BUNDLE_W-1:0] push_data;
  logic [BUNDLE_W-1:0] head;
  logic                push;
  logic                pop;
  q_status_t           q_status;
  logic [PB-1:0]       start_w, end_w, line_w;

  jtl_front #(
    .POSITION_BITS (POSITION_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .text_byte_i  (text_byte_i),
    .stream_end_i (stream_end_i),
    .q_status_i   (q_status),
    .push_o       (push),
    .bundle_o     (push_data)
  );

  jtl_fifo #(
    .WIDTH (BUNDLE_W)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .status_o    (q_status)
  );

  jtl_back #(
    .POSITION_BITS (POSITION_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .q_status_i    (q_status),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .token_kind_o  (token_kind_o),
    .token_start_o (start_w),
    .token_end_o   (end_w),
    .line_number_o (line_w),
    .run_last_o    (run_last_o)
  );

  // Show the low bits of each position on the fixed-width ports
  assign token_start_o = OUT_POS_BITS'(start_w);
  assign token_end_o   = OUT_POS_BITS'(end_w);
  assign line_number_o = OUT_POS_BITS'(line_w);

endmodule

// ----- tb/json_lexer_checker.sv -----
`timescale 1ns / 1ps

module json_lexer_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  text_byte_i,
  input  logic        stream_end_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [3:0]  token_kind_i,
  input  logic [23:0] token_start_i,
  input  logic [23:0] token_end_i,
  input  logic [23:0] line_number_i,
  input  logic        run_last_i,
  output int          fail_count_o,
  output int          pending_o
);
  import jtl_pkg::*;

  typedef struct {
    token_kind_e kind;
    logic [23:0] first;
    logic [23:0] past;
    logic [23:0] line;
    logic        last;
  } token_t;

  // Tokens predicted but not yet seen on the output channel
  token_t tokens_due[$];
  int mismatches = 0;
  int due_count = 0;

  // Lexer state mirror
  lex_mode_e   mode_q    = MODE_IDLE;
  logic [23:0] pos_q     = '0;
  logic [23:0] lines_q   = '0;
  logic [23:0] start_q   = '0;
  logic [2:0]  kw_idx_q  = '0;
  logic [1:0]  kw_kind_q = KW_TRUE;
  logic        dot_q     = 1'b0;

  string keyword_text [3] = '{"true", "null", "false"};

  assign fail_count_o = mismatches;
  assign pending_o    = due_count;

  // Saturating position step
  function automatic logic [23:0] bump(input logic [23:0] v);
    return (v == '1) ? v : v + 24'd1;
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= CH_ZERO) && (b <= CH_NINE);
  endfunction

  task automatic push_token(input token_kind_e kind, input logic [23:0] first,
                            input logic [23:0] past);
    token_t t;
    t.kind  = kind;
    t.first = first;
    t.past  = past;
    t.line  = lines_q;
    t.last  = 1'b0;
    tokens_due.push_back(t);
  endtask

  task automatic clear_state();
    mode_q    = MODE_IDLE;
    pos_q     = '0;
    lines_q   = '0;
    start_q   = '0;
    kw_idx_q  = '0;
    kw_kind_q = KW_TRUE;
    dot_q     = 1'b0;
  endtask

  // Lex a byte that arrives between tokens
  task automatic lex_fresh(input logic [7:0] b, input logic [23:0] pos,
                           input logic [23:0] nxt);
    case (b)
      CH_SPACE, CH_CR: begin
      end
      CH_LF: lines_q = bump(lines_q);
      CH_QUOTE: begin
        mode_q  = MODE_STRING;
        start_q = pos;
      end
      CH_COLON:  push_token(TOK_COLON, pos, nxt);
      CH_COMMA:  push_token(TOK_COMMA, pos, nxt);
      CH_LBRACE: push_token(TOK_LBRACE, pos, nxt);
      CH_RBRACE: push_token(TOK_RBRACE, pos, nxt);
      CH_LBRACK: push_token(TOK_LBRACKET, pos, nxt);
      CH_RBRACK: push_token(TOK_RBRACKET, pos, nxt);
      CH_MINUS: begin
        mode_q  = MODE_MINUS;
        start_q = pos;
      end
      CH_LOW_T, CH_LOW_N, CH_LOW_F: begin
        mode_q    = MODE_KEYWORD;
        start_q   = pos;
        kw_kind_q = (b == CH_LOW_T) ? KW_TRUE : ((b == CH_LOW_N) ? KW_NULL : KW_FALSE);
        kw_idx_q  = 3'd1;
      end
      default: begin
        if (is_digit(b)) begin
          mode_q  = MODE_NUMBER;
          start_q = pos;
          dot_q   = 1'b0;
        end else begin
          push_token(TOK_INVALID, pos, pos);
          mode_q = MODE_SKIP;
        end
      end
    endcase
  endtask

  // Advance the mirror by one word and queue the tokens it makes
  task automatic predict_byte(input logic [7:0] b, input logic last);
    logic [23:0] pos;
    logic [23:0] nxt;
    int          queued;
    pos    = pos_q;
    nxt    = bump(pos);
    queued = tokens_due.size();

    case (mode_q)
      MODE_STRING: begin
        if (b == CH_QUOTE) begin
          push_token(TOK_STRING, start_q, nxt);
          mode_q = MODE_IDLE;
        end
      end
      MODE_MINUS: begin
        if (is_digit(b)) begin
          mode_q = MODE_NUMBER;
          dot_q  = 1'b0;
        end else begin
          push_token(TOK_INVALID, start_q, pos);
          mode_q = MODE_SKIP;
        end
      end
      MODE_NUMBER: begin
        if (b == CH_DOT) begin
          if (dot_q) begin
            push_token(TOK_INVALID, start_q, pos);
            mode_q = MODE_SKIP;
          end else begin
            dot_q = 1'b1;
          end
        end else if (!is_digit(b)) begin
          // The number closes here; the same byte may then open a new token
          push_token(dot_q ? TOK_FLOAT : TOK_INT, start_q, pos);
          mode_q = MODE_IDLE;
          lex_fresh(b, pos, nxt);
        end
      end
      MODE_KEYWORD: begin
        if (kw_idx_q < keyword_text[kw_kind_q].len() &&
            b == keyword_text[kw_kind_q][kw_idx_q]) begin
          kw_idx_q = kw_idx_q + 3'd1;
          if (kw_idx_q >= keyword_text[kw_kind_q].len() && !last) begin
            push_token((kw_kind_q == KW_NULL) ? TOK_NULL : TOK_BOOL, start_q, nxt);
            mode_q = MODE_IDLE;
          end
        end else begin
          push_token(TOK_INVALID, start_q, pos);
          mode_q = MODE_SKIP;
        end
      end
      MODE_SKIP: begin
      end
      default: begin
        mode_q = MODE_IDLE;
        lex_fresh(b, pos, nxt);
      end
    endcase

    pos_q = nxt;

    // Flush any open token, close the stream, start over
    if (last) begin
      case (mode_q)
        MODE_STRING:  push_token(TOK_EOF, start_q, nxt);
        MODE_MINUS:   push_token(TOK_INVALID, start_q, nxt);
        MODE_NUMBER:  push_token(dot_q ? TOK_FLOAT : TOK_INT, start_q, nxt);
        MODE_KEYWORD: push_token(TOK_INVALID, start_q, nxt);
        default: begin
        end
      endcase
      push_token(TOK_EOF, nxt, nxt);
      clear_state();
    end

    if (tokens_due.size() > queued) begin
      tokens_due[tokens_due.size() - 1].last = 1'b1;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [23:0] got,
                                 input logic [23:0] want);
    $display("%0t ns: token %s mismatch: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  // Sample both channels; predict from input words, compare output words
  always @(posedge clk_i) begin : watch
    token_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_i) begin
        predict_byte(text_byte_i, stream_end_i);
      end
      if (out_valid_i && out_ready_i) begin
        if (tokens_due.size() == 0) begin
          report_mismatch("unexpected, kind", 24'(token_kind_i), '0);
        end else begin
          want = tokens_due.pop_front();
          if (token_kind_i != want.kind) begin
            report_mismatch("kind", 24'(token_kind_i), 24'(want.kind));
          end
          if (token_start_i != want.first) report_mismatch("start", token_start_i, want.first);
          if (token_end_i != want.past) report_mismatch("end", token_end_i, want.past);
          if (line_number_i != want.line) report_mismatch("line", line_number_i, want.line);
          if (run_last_i != want.last) begin
            report_mismatch("run_last", 24'(run_last_i), 24'(want.last));
          end
        end
      end
      due_count = tokens_due.size();
    end
  end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import jtl_pkg::*;

  // Slowest run: ~530 words, up to 3 tokens each, heavy receiver stalls
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_BYTES = 160;

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        in_valid_i   = 1'b0;
  logic        in_ready_o;
  logic [7:0]  text_byte_i  = 8'h00;
  logic        stream_end_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i  = 1'b0;
  logic [3:0]  token_kind_o;
  logic [23:0] token_start_o;
  logic [23:0] token_end_o;
  logic [23:0] line_number_o;
  logic        run_last_o;

  int fail_count;
  int pending;
  int cycle_count  = 0;
  int send_gap_pct = 29;
  int recv_gap_pct = 82;
  int phase_bytes  = 0;

  logic [7:0] text_buf[$];
  logic [7:0] punct_chars [6] = '{CH_COLON, CH_COMMA, CH_LBRACE, CH_RBRACE,
                                  CH_LBRACK, CH_RBRACK};
  string      keywords [3] = '{"true", "null", "false"};

  json_token_lexer uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .text_byte_i   (text_byte_i),
    .stream_end_i  (stream_end_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .token_kind_o  (token_kind_o),
    .token_start_o (token_start_o),
    .token_end_o   (token_end_o),
    .line_number_o (line_number_o),
    .run_last_o    (run_last_o)
  );

  json_lexer_checker token_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .text_byte_i   (text_byte_i),
    .stream_end_i  (stream_end_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .token_kind_i  (token_kind_o),
    .token_start_i (token_start_o),
    .token_end_i   (token_end_o),
    .line_number_i (line_number_o),
    .run_last_i    (run_last_o),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  always #10 clk_i = ~clk_i;

  // Stall the output side at random
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_gap_pct);
  end

  // Bound the run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d tokens outstanding", cycle_count, pending);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Present one word, hold it until taken; entered and left at a falling edge
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    text_byte_i  <= b;
    stream_end_i <= last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Send the buffered stream, marking its final byte
  task automatic send_text();
    for (int i = 0; i < text_buf.size(); i++) begin
      send_byte(text_buf[i], i == text_buf.size() - 1);
    end
    phase_bytes += text_buf.size();
    text_buf.delete();
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
  endtask

  task automatic put_digit();
    text_buf.push_back(CH_ZERO + 8'($urandom_range(9)));
  endtask

  task automatic put_number();
    int n;
    n = $urandom_range(1, 3);
    if ($urandom_range(2) == 0) text_buf.push_back(CH_MINUS);
    repeat (n) put_digit();
    if ($urandom_range(9) < 4) begin
      text_buf.push_back(CH_DOT);
      n = $urandom_range(2);
      repeat (n) put_digit();
    end
  endtask

  // String body of random bytes, never a quote
  task automatic put_string_body(input int n);
    logic [7:0] b;
    repeat (n) begin
      b = 8'($urandom_range(255));
      if (b == CH_QUOTE) b = CH_LF;
      text_buf.push_back(b);
    end
  endtask

  task automatic put_token(input bit allow_bad);
    int    pick;
    string kw;
    pick = allow_bad ? $urandom_range(99) : $urandom_range(87);
    if (pick < 10) begin
      text_buf.push_back($urandom_range(1) ? CH_CR : CH_SPACE);
    end else if (pick < 25) begin
      text_buf.push_back(CH_QUOTE);
      put_string_body($urandom_range(4));
      text_buf.push_back(CH_QUOTE);
    end else if (pick < 45) begin
      text_buf.push_back(punct_chars[$urandom_range(5)]);
    end else if (pick < 65) begin
      put_number();
    end else if (pick < 85) begin
      put_text(keywords[$urandom_range(2)]);
    end else if (pick < 88) begin
      text_buf.push_back(8'($urandom_range(255)));
    end else begin
      // Malformed tokens
      kw = keywords[$urandom_range(2)];
      case ($urandom_range(3))
        0: begin
          text_buf.push_back(CH_MINUS);
          text_buf.push_back(punct_chars[$urandom_range(5)]);
        end
        1: begin
          put_digit();
          text_buf.push_back(CH_DOT);
          put_digit();
          text_buf.push_back(CH_DOT);
          put_digit();
        end
        2: begin
          put_text(kw.substr(0, $urandom_range(1, kw.len() - 2)));
          text_buf.push_back($urandom_range(1) ? CH_SPACE : CH_LOW_T);
        end
        default: begin
          put_text(kw);
          put_text("q");
        end
      endcase
    end
  endtask

  // Build one stream: tokens with separators, sometimes an open tail
  task automatic build_stream();
    bit allow_bad;
    int n;
    allow_bad = ($urandom_range(3) == 0);
    n = $urandom_range(1, 6);
    repeat (n) begin
      put_token(allow_bad);
      if ($urandom_range(9) < 4) text_buf.push_back($urandom_range(1) ? CH_LF : CH_SPACE);
    end
    if ($urandom_range(4) == 0) begin
      case ($urandom_range(3))
        0: begin
          text_buf.push_back(CH_QUOTE);
          put_string_body($urandom_range(3));
        end
        1: put_number();
        2: put_text(keywords[$urandom_range(2)]);
        default: text_buf.push_back(CH_MINUS);
      endcase
    end
  endtask

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: every token kind but Bool, line feed, keyword on the final byte,
    // keyword then unknown byte, unterminated string, byte extremes
    put_text("{\"a\":[-1.5,\n2]}");
    send_text();
    put_text("false");
    send_text();
    put_text("null");
    text_buf.push_back(8'hFF);
    send_text();
    text_buf.push_back(CH_QUOTE);
    text_buf.push_back(8'h00);
    send_text();

    // Random streams in three idling phases; drain between phases
    for (int phase = 0; phase < 3; phase++) begin
      send_gap_pct = (phase == 0) ? 29 : ((phase == 1) ? 82 : 0);
      recv_gap_pct = (phase == 0) ? 82 : ((phase == 1) ? 29 : 0);
      phase_bytes  = 0;
      while (phase_bytes < PHASE_BYTES) begin
        build_stream();
        send_text();
      end
      in_valid_i <= 1'b0;
      @(negedge clk_i);
      while (pending != 0) @(negedge clk_i);
    end

    repeat (20) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/jtl_pkg.sv
design/jtl_front.sv
design/jtl_fifo.sv
design/jtl_back.sv
design/json_token_lexer.sv
tb/json_lexer_checker.sv
tb/testbench.sv
